FILE: src/gzip_header_stripper_macros.svh
// Assertion macros for the gzip header stripper.
// Used inside modules that have clk and rst in scope.
`ifndef GZIP_HEADER_STRIPPER_MACROS_SVH
`define GZIP_HEADER_STRIPPER_MACROS_SVH

// Same-cycle implication, off during reset.
`define GHS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define GHS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/ghs_pkg.sv
// Types, codes and constants for the gzip header stripper.
// No dependencies.
package ghs_pkg;

  localparam int unsigned LENGTH_WIDTH_DEFAULT = 32;
  localparam int unsigned CFG_WIDTH = 32;

  localparam int unsigned MIN_MEMBER   = 18;
  localparam int unsigned FOOTER_BYTES = 8;
  localparam int unsigned FLG_POS      = 3;
  localparam int unsigned LAST_FIXED   = 9;

  localparam logic [7:0] ID1_BYTE    = 8'h1f;
  localparam logic [7:0] ID2_BYTE    = 8'h8b;
  localparam logic [7:0] CM_DEFLATE  = 8'h08;
  localparam logic [7:0] FL_HCRC     = 8'h02;
  localparam logic [7:0] FL_EXTRA    = 8'h04;
  localparam logic [7:0] FL_NAME     = 8'h08;
  localparam logic [7:0] FL_COMMENT  = 8'h10;
  localparam logic [7:0] FL_RESERVED = 8'he0;

  typedef enum logic [3:0] {
    PH_FIXED   = 4'd0,
    PH_XLEN_LO = 4'd1,
    PH_XLEN_HI = 4'd2,
    PH_XDATA   = 4'd3,
    PH_NAME    = 4'd4,
    PH_COMMENT = 4'd5,
    PH_HCRC_LO = 4'd6,
    PH_HCRC_HI = 4'd7,
    PH_PAYLOAD = 4'd8
  } phase_t;

  typedef enum logic [1:0] {
    CLS_HEADER  = 2'd0,
    CLS_PAYLOAD = 2'd1,
    CLS_FOOTER  = 2'd2,
    CLS_ERROR   = 2'd3
  } class_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_SHORT     = 3'd1,
    ERR_BAD_ID    = 3'd2,
    ERR_BAD_CM    = 3'd3,
    ERR_RESERVED  = 3'd4,
    ERR_EXTRA_LEN = 3'd5,
    ERR_OVERRUN   = 3'd6
  } err_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    class_t     byte_class;
    err_t       error_code;
    logic       header_done;
  } out_word_t;

  // First enabled optional section at or after the candidate phase.
  function automatic phase_t section_from(input logic [7:0] flags, input phase_t cand);
    phase_t res;
    priority if (cand <= PH_XLEN_LO && (flags & FL_EXTRA) != 8'h00) res = PH_XLEN_LO;
    else if (cand <= PH_NAME && (flags & FL_NAME) != 8'h00) res = PH_NAME;
    else if (cand <= PH_COMMENT && (flags & FL_COMMENT) != 8'h00) res = PH_COMMENT;
    else if (cand <= PH_HCRC_LO && (flags & FL_HCRC) != 8'h00) res = PH_HCRC_LO;
    else res = PH_PAYLOAD;
    return res;
  endfunction

endpackage

FILE: src/gzip_header_stripper.sv
// A byte is parsed in one pass between the input register and the result register.
// Throughput: one byte per cycle while not stalled; parse state updates once per byte.
// Input stall follows output stall only when the result register is full and held.
// Reset (rst, synchronous, active high) clears the parse state, the length register
// and both valid flags; the first byte after reset parses as a fresh member.
`include "gzip_header_stripper_macros.svh"

module gzip_header_stripper #(
  parameter int unsigned LENGTH_WIDTH = ghs_pkg::LENGTH_WIDTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [ghs_pkg::CFG_WIDTH-1:0]  cfg_wr_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  ghs_pkg::in_word_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output ghs_pkg::out_word_t             out_data
);
  import ghs_pkg::*;

  localparam int unsigned LW = LENGTH_WIDTH;
  localparam logic [LW-1:0] POS_MAX = {LW{1'b1}};

  // pipeline control
  logic      adv;
  logic      s1_valid;
  in_word_t  s1_data;
  logic      proc;

  // parse state
  logic [LW-1:0] total_len;
  logic [LW-1:0] position;
  phase_t        phase;
  logic [7:0]    flag_bits;
  logic [15:0]   extra_remaining;
  logic [7:0]    extra_low_latch;
  err_t          sticky_error;

  // effective state after a possible restart
  logic [LW-1:0] pos;
  phase_t        eff_phase;
  logic [7:0]    eff_flags;
  logic [15:0]   eff_rem;
  logic [7:0]    eff_low;
  err_t          eff_sticky;

  logic [LW-1:0] fstart;
  logic [LW-1:0] room;
  logic [15:0]   xlen;
  logic [15:0]   rem_dec;
  logic [7:0]    b;

  logic [LW-1:0] position_next;
  phase_t        phase_next;
  phase_t        nxt;
  logic [7:0]    flag_bits_next;
  logic [15:0]   extra_remaining_next;
  logic [7:0]    extra_low_latch_next;
  err_t          sticky_error_next;
  err_t          err;
  class_t        cls;
  logic          done;
  out_word_t     res;

  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;
  assign proc     = s1_valid && adv;

  assign b          = s1_data.data_byte;
  assign pos        = s1_data.first_byte ? '0 : position;
  assign eff_phase  = s1_data.first_byte ? PH_FIXED : phase;
  assign eff_flags  = s1_data.first_byte ? 8'h00 : flag_bits;
  assign eff_rem    = s1_data.first_byte ? 16'h0000 : extra_remaining;
  assign eff_low    = s1_data.first_byte ? 8'h00 : extra_low_latch;
  assign eff_sticky = s1_data.first_byte ? ERR_NONE : sticky_error;

  assign fstart  = (total_len < LW'(FOOTER_BYTES)) ? '0 : total_len - LW'(FOOTER_BYTES);
  // bytes left before the footer after this one; valid only while pos < fstart
  assign room    = fstart - pos - LW'(1);
  assign xlen    = {b, eff_low};
  assign rem_dec = eff_rem - 16'd1;
  assign position_next = (pos == POS_MAX) ? pos : pos + LW'(1);

  always_comb begin
    phase_next           = eff_phase;
    nxt                  = eff_phase;
    flag_bits_next       = eff_flags;
    extra_remaining_next = eff_rem;
    extra_low_latch_next = eff_low;
    err                  = ERR_NONE;
    cls                  = CLS_HEADER;
    done                 = 1'b0;
    if (eff_sticky == ERR_NONE) begin
      priority if (eff_phase == PH_PAYLOAD) begin
        cls = (pos < fstart) ? CLS_PAYLOAD : CLS_FOOTER;
      end else if (eff_phase == PH_FIXED && pos == '0 && total_len < LW'(MIN_MEMBER)) begin
        err = ERR_SHORT;
      end else if (pos >= fstart) begin
        err = ERR_OVERRUN;
      end else begin
        unique case (eff_phase)
          PH_FIXED: begin
            priority if (pos == LW'(0) && b != ID1_BYTE) err = ERR_BAD_ID;
            else if (pos == LW'(1) && b != ID2_BYTE) err = ERR_BAD_ID;
            else if (pos == LW'(2) && b != CM_DEFLATE) err = ERR_BAD_CM;
            else if (pos == LW'(FLG_POS)) begin
              flag_bits_next = b;
              if ((b & FL_RESERVED) != 8'h00) err = ERR_RESERVED;
            end else begin
              err = ERR_NONE;
            end
            if (pos >= LW'(LAST_FIXED)) nxt = section_from(flag_bits_next, PH_XLEN_LO);
          end
          PH_XLEN_LO: begin
            extra_low_latch_next = b;
            nxt = PH_XLEN_HI;
          end
          PH_XLEN_HI: begin
            priority if (room < LW'(xlen)) err = ERR_EXTRA_LEN;
            else if (xlen == 16'h0000) nxt = section_from(eff_flags, PH_NAME);
            else begin
              extra_remaining_next = xlen;
              nxt = PH_XDATA;
            end
          end
          PH_XDATA: begin
            extra_remaining_next = rem_dec;
            if (rem_dec == 16'h0000) nxt = section_from(eff_flags, PH_NAME);
          end
          PH_NAME: begin
            if (b == 8'h00) nxt = section_from(eff_flags, PH_COMMENT);
          end
          PH_COMMENT: begin
            if (b == 8'h00) nxt = section_from(eff_flags, PH_HCRC_LO);
          end
          PH_HCRC_LO: begin
            nxt = PH_HCRC_HI;
          end
          default: begin
            nxt = PH_PAYLOAD;
          end
        endcase
        if (err == ERR_NONE) begin
          phase_next = nxt;
          done = (nxt == PH_PAYLOAD);
        end
      end
    end
    sticky_error_next = (err != ERR_NONE) ? err : eff_sticky;
    // hold the sticky code on every byte until the next restart
    if (sticky_error_next != ERR_NONE) begin
      cls  = CLS_ERROR;
      err  = sticky_error_next;
      done = 1'b0;
    end
    res.payload_byte = (cls == CLS_PAYLOAD) ? b : 8'h00;
    res.byte_class   = cls;
    res.error_code   = err;
    res.header_done  = done;
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid;
    end
    if (adv && in_valid) begin
      s1_data <= in_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s1_valid;
    end
    if (proc) begin
      out_data <= res;
    end
  end

  // length register and parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      total_len       <= '0;
      position        <= '0;
      phase           <= PH_FIXED;
      flag_bits       <= 8'h00;
      extra_remaining <= 16'h0000;
      extra_low_latch <= 8'h00;
      sticky_error    <= ERR_NONE;
    end else begin
      if (cfg_wr_en) begin
        total_len <= LW'(cfg_wr_data);
      end
      if (proc) begin
        position        <= position_next;
        phase           <= phase_next;
        flag_bits       <= flag_bits_next;
        extra_remaining <= extra_remaining_next;
        extra_low_latch <= extra_low_latch_next;
        sticky_error    <= sticky_error_next;
      end
    end
  end

  `GHS_ASSERT_NOW(a_err_only_on_error, out_valid && out_data.byte_class != CLS_ERROR, out_data.error_code == ERR_NONE, "error code outside error class")
  `GHS_ASSERT_NOW(a_done_is_header, out_valid && out_data.header_done, out_data.byte_class == CLS_HEADER, "header_done on non-header word")
  `GHS_ASSERT_NEXT(a_s1_held, s1_valid && !adv, s1_valid, "held word dropped from input register")
  `GHS_ASSERT_NEXT(a_err_sticks, proc && sticky_error_next != ERR_NONE && !(in_valid && !in_stall && in_data.first_byte), sticky_error != ERR_NONE, "sticky error cleared without restart")

endmodule
